// ----- rtl/core/oal_pkg.sv -----
// ============================================================================
// oal_pkg
// Shared types and constants for the ordered array list core.
// ============================================================================
package oal_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 32;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND  = 3'd0,
    MODE_INSERT  = 3'd1,
    MODE_DELETE  = 3'd2,
    MODE_REPLACE = 3'd3,
    MODE_READ    = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_INS_PRIME,
    S_INS_SHIFT,
    S_INS_LAST,
    S_DEL_PRIME,
    S_DEL_SHIFT,
    S_RD_WAIT,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    RA_POS,
    RA_PTR_M1,
    RA_PTR_M2,
    RA_PTR_P1,
    RA_PTR_P2
  } raddr_sel_t;

  typedef enum logic [1:0] {
    WA_CNT,
    WA_POS,
    WA_PTR
  } waddr_sel_t;

  typedef enum logic {
    WS_VALUE,
    WS_RAM
  } wsrc_t;

  // Controller -> datapath
  typedef struct packed {
    logic       load;
    logic       status_load;
    status_t    status;
    logic       ptr_load_count;
    logic       ptr_load_pos;
    logic       ptr_inc;
    logic       ptr_dec;
    raddr_sel_t raddr_sel;
    logic       we;
    waddr_sel_t waddr_sel;
    wsrc_t      wsrc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       rd_capture;
    logic       out_load;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              ins_bad;
    logic              pos_bad;
    logic              pos_at_end;
    logic              pos_at_last;
    logic              ptr_at_pos1;
    logic              ptr_p2_at_count;
  } sts_t;

endpackage

// ----- rtl/core/oal_req_if.sv -----
// ============================================================================
// oal_req_if
// Request channel: mode, value and position with valid/ready.
// ============================================================================
interface oal_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [oal_pkg::MODE_W-1:0]            mode;
  logic signed [oal_pkg::VALUE_W-1:0]    value;
  logic [oal_pkg::POS_W-1:0]             position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

// ----- rtl/core/oal_rsp_if.sv -----
// ============================================================================
// oal_rsp_if
// Response channel: status, count and read value with valid/ready.
// ============================================================================
interface oal_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [oal_pkg::STATUS_W-1:0]          status;
  logic [oal_pkg::COUNT_W-1:0]           count;
  logic signed [oal_pkg::VALUE_W-1:0]    read_value;

  modport source (output valid, output status, output count, output read_value, input ready);
  modport sink   (input valid, input status, input count, input read_value, output ready);
endinterface

// ----- rtl/core/ordered_array_list_core.sv -----
// ============================================================================
// ordered_array_list_core
// Ordered list of signed 32-bit values with append/insert/delete/replace/read.
// ============================================================================
// Append, replace, rejected and unused modes go from execute to finish; read
//   adds a read-wait state; insert in the middle and delete short of the last
//   element add a prime state and a shift loop, insert also a last-write state.
// One request at a time; the single write port of the element RAM moves one
//   element per cycle during insert and delete.
// Reset: count goes to zero; element storage is not cleared and needs no pass.
// ============================================================================
module ordered_array_list_core #(
  parameter int unsigned CAPACITY = oal_pkg::DEFAULT_CAPACITY
) (
  input logic    clk,
  input logic    rst,
  oal_req_if.sink   req,
  oal_rsp_if.source rsp
);

  // Command and status between the sequencer and the datapath. The sequencer
  // owns the handshakes; the datapath owns every payload and storage element.
  oal_pkg::cmd_t cmd;
  oal_pkg::sts_t sts;

  // Sequencer: takes one request at a time, walks the shift loop one element
  // per cycle, and parks the finished result in the output register so the
  // next request can be taken while the result still waits for its transfer.
  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: request capture, element count, shift pointer, element RAM
  // (registered read) and the result register that drives the response.
  oal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .mode       (req.mode),
    .value      (req.value),
    .position   (req.position),
    .status     (rsp.status),
    .count      (rsp.count),
    .read_value (rsp.read_value)
  );

endmodule

// ----- rtl/core/oal_ram.sv -----
// ============================================================================
// oal_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module oal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/oal_ctrl.sv -----
// ============================================================================
// oal_ctrl
// Request sequencer: decodes the mode, steps the shift loops, hands off results.
// ============================================================================
module oal_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  oal_pkg::sts_t sts,
  output oal_pkg::cmd_t cmd
);

  oal_pkg::state_t state;
  oal_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == oal_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oal_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      oal_pkg::S_IDLE: begin
        if (in_valid) state_next = oal_pkg::S_EXEC;
      end
      oal_pkg::S_EXEC: begin
        state_next = oal_pkg::S_FINISH;
        case (sts.mode)
          oal_pkg::MODE_INSERT: begin
            if (!sts.full && !sts.ins_bad && !sts.pos_at_end) state_next = oal_pkg::S_INS_PRIME;
          end
          oal_pkg::MODE_DELETE: begin
            if (!sts.pos_bad && !sts.pos_at_last) state_next = oal_pkg::S_DEL_PRIME;
          end
          oal_pkg::MODE_READ: begin
            if (!sts.pos_bad) state_next = oal_pkg::S_RD_WAIT;
          end
          default: state_next = oal_pkg::S_FINISH;
        endcase
      end
      oal_pkg::S_INS_PRIME: state_next = oal_pkg::S_INS_SHIFT;
      oal_pkg::S_INS_SHIFT: begin
        if (sts.ptr_at_pos1) state_next = oal_pkg::S_INS_LAST;
      end
      oal_pkg::S_INS_LAST:  state_next = oal_pkg::S_FINISH;
      oal_pkg::S_DEL_PRIME: state_next = oal_pkg::S_DEL_SHIFT;
      oal_pkg::S_DEL_SHIFT: begin
        if (sts.ptr_p2_at_count) state_next = oal_pkg::S_FINISH;
      end
      oal_pkg::S_RD_WAIT:   state_next = oal_pkg::S_FINISH;
      oal_pkg::S_FINISH: begin
        if (out_free) state_next = oal_pkg::S_IDLE;
      end
      default: state_next = oal_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.status    = oal_pkg::ST_OK;
    cmd.raddr_sel = oal_pkg::RA_POS;
    cmd.waddr_sel = oal_pkg::WA_POS;
    cmd.wsrc      = oal_pkg::WS_VALUE;
    case (state)
      oal_pkg::S_IDLE: begin
        cmd.load = in_valid;
      end
      oal_pkg::S_EXEC: begin
        cmd.status_load = 1'b1;
        case (sts.mode)
          oal_pkg::MODE_APPEND: begin
            if (sts.full) begin
              cmd.status = oal_pkg::ST_FULL;
            end else begin
              cmd.we        = 1'b1;
              cmd.waddr_sel = oal_pkg::WA_CNT;
              cmd.cnt_inc   = 1'b1;
            end
          end
          oal_pkg::MODE_INSERT: begin
            if (sts.full) begin
              cmd.status = oal_pkg::ST_FULL;
            end else if (sts.ins_bad) begin
              cmd.status = oal_pkg::ST_BADPOS;
            end else if (sts.pos_at_end) begin
              cmd.we      = 1'b1;
              cmd.cnt_inc = 1'b1;
            end else begin
              cmd.ptr_load_count = 1'b1;
            end
          end
          oal_pkg::MODE_DELETE: begin
            if (sts.pos_bad) begin
              cmd.status = oal_pkg::ST_BADPOS;
            end else if (sts.pos_at_last) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.ptr_load_pos = 1'b1;
            end
          end
          oal_pkg::MODE_REPLACE: begin
            if (sts.pos_bad) cmd.status = oal_pkg::ST_BADPOS;
            else             cmd.we     = 1'b1;
          end
          oal_pkg::MODE_READ: begin
            if (sts.pos_bad) cmd.status = oal_pkg::ST_BADPOS;
          end
          default: cmd.status = oal_pkg::ST_OK;
        endcase
      end
      oal_pkg::S_INS_PRIME: begin
        cmd.raddr_sel = oal_pkg::RA_PTR_M1;
      end
      oal_pkg::S_INS_SHIFT: begin
        cmd.we        = 1'b1;
        cmd.waddr_sel = oal_pkg::WA_PTR;
        cmd.wsrc      = oal_pkg::WS_RAM;
        cmd.raddr_sel = oal_pkg::RA_PTR_M2;
        cmd.ptr_dec   = 1'b1;
      end
      oal_pkg::S_INS_LAST: begin
        cmd.we      = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      oal_pkg::S_DEL_PRIME: begin
        cmd.raddr_sel = oal_pkg::RA_PTR_P1;
      end
      oal_pkg::S_DEL_SHIFT: begin
        cmd.we        = 1'b1;
        cmd.waddr_sel = oal_pkg::WA_PTR;
        cmd.wsrc      = oal_pkg::WS_RAM;
        cmd.raddr_sel = oal_pkg::RA_PTR_P2;
        cmd.ptr_inc   = 1'b1;
        cmd.cnt_dec   = sts.ptr_p2_at_count;
      end
      oal_pkg::S_RD_WAIT: begin
        cmd.rd_capture = 1'b1;
      end
      oal_pkg::S_FINISH: begin
        cmd.out_load = out_free;
      end
      default: cmd.load = 1'b0;
    endcase
  end

  // no storage write outside request execution
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == oal_pkg::S_IDLE || state == oal_pkg::S_FINISH) |-> !cmd.we)
    else $error("storage write outside request execution");

  // a result waiting at the output is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("pending result overwritten");

endmodule

// ----- rtl/core/oal_dp.sv -----
// ============================================================================
// oal_dp
// Datapath: request registers, element count, shift pointer, storage, result.
// ============================================================================
module oal_dp #(
  parameter int unsigned CAPACITY = oal_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  oal_pkg::cmd_t                       cmd,
  output oal_pkg::sts_t                       sts,
  input  logic [oal_pkg::MODE_W-1:0]          mode,
  input  logic signed [oal_pkg::VALUE_W-1:0]  value,
  input  logic [oal_pkg::POS_W-1:0]           position,
  output logic [oal_pkg::STATUS_W-1:0]        status,
  output logic [oal_pkg::COUNT_W-1:0]         count,
  output logic signed [oal_pkg::VALUE_W-1:0]  read_value
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W) + 2;

  logic [oal_pkg::MODE_W-1:0]          req_mode;
  logic signed [oal_pkg::VALUE_W-1:0]  req_value;
  logic [oal_pkg::POS_W-1:0]           req_pos;
  oal_pkg::status_t                    res_status;
  logic signed [oal_pkg::VALUE_W-1:0]  rd;
  logic [CW-1:0]                       cnt;
  logic [CW-1:0]                       ptr;

  logic [XW-1:0] cnt_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] ptr_x;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] raddr_c;
  logic [CW-1:0] waddr_c;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [oal_pkg::VALUE_W-1:0] wdata;
  logic [oal_pkg::VALUE_W-1:0] rdata;

  assign cnt_x = XW'(cnt);
  assign pos_x = XW'(req_pos);
  assign ptr_x = XW'(ptr);
  assign pos_c = CW'(pos_x);

  assign sts.mode            = req_mode;
  assign sts.full            = (cnt_x == XW'(CAPACITY));
  assign sts.ins_bad         = (pos_x > cnt_x);
  assign sts.pos_bad         = (pos_x >= cnt_x);
  assign sts.pos_at_end      = (pos_x == cnt_x);
  assign sts.pos_at_last     = ((pos_x + XW'(1)) == cnt_x);
  assign sts.ptr_at_pos1     = (ptr_x == (pos_x + XW'(1)));
  assign sts.ptr_p2_at_count = ((ptr_x + XW'(2)) == cnt_x);

  always_comb begin
    case (cmd.raddr_sel)
      oal_pkg::RA_PTR_M1: raddr_c = ptr - CW'(1);
      oal_pkg::RA_PTR_M2: raddr_c = ptr - CW'(2);
      oal_pkg::RA_PTR_P1: raddr_c = ptr + CW'(1);
      oal_pkg::RA_PTR_P2: raddr_c = ptr + CW'(2);
      default:            raddr_c = pos_c;
    endcase
    case (cmd.waddr_sel)
      oal_pkg::WA_CNT: waddr_c = cnt;
      oal_pkg::WA_PTR: waddr_c = ptr;
      default:         waddr_c = pos_c;
    endcase
  end

  assign raddr = raddr_c[AW-1:0];
  assign waddr = waddr_c[AW-1:0];
  assign wdata = (cmd.wsrc == oal_pkg::WS_RAM) ? rdata : req_value;

  oal_ram #(
    .WIDTH (oal_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - CW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode  <= mode;
      req_value <= value;
      req_pos   <= position;
      rd        <= '0;
    end else if (cmd.rd_capture) begin
      rd <= rdata;
    end
    if (cmd.status_load) begin
      res_status <= cmd.status;
    end
    if (cmd.ptr_load_count) begin
      ptr <= cnt;
    end else if (cmd.ptr_load_pos) begin
      ptr <= pos_c;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + CW'(1);
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - CW'(1);
    end
    if (cmd.out_load) begin
      status     <= res_status;
      count      <= oal_pkg::COUNT_W'(cnt_x);
      read_value <= rd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_x <= XW'(CAPACITY))
    else $error("element count above capacity");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !sts.full)
    else $error("count raised on a full list");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> (cnt != '0))
    else $error("count lowered on an empty list");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.we |-> (XW'(waddr_c) < XW'(CAPACITY)))
    else $error("storage write beyond capacity");

endmodule
